// File: hw/rtl/idcd_pkg.sv
// ----------------------------------------------------------------------------
// idcd_pkg
// Shared types and constants of the impulse double-click detector.
// ----------------------------------------------------------------------------
package idcd_pkg;

  localparam int NUM_PLAYERS_DEF  = 16;
  localparam int NUM_CONTROLS_DEF = 64;

  localparam int REQ_W     = 2;
  localparam int PLAYER_W  = 4;
  localparam int CONTROL_W = 6;
  localparam int POS_W     = 16;
  localparam int TIME_W    = 32;
  localparam int THRESH_W  = 11;
  localparam int COUNT_W   = 15;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd300;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 15'h7FFF;

  // Class boundaries in Q2.14: +0.5 and -0.5, both compared strictly.
  localparam logic signed [POS_W-1:0] POS_HALF = 16'sd8192;
  localparam logic signed [POS_W-1:0] NEG_HALF = -16'sd8192;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_PULSE      = 2'd1,
    REQ_TAKE_COUNT = 2'd2,
    REQ_TAKE_FLAG  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    LVL_RELEASED = 2'd0,
    LVL_POS      = 2'd1,
    LVL_NEG      = 2'd2
  } level_t;

  typedef struct packed {
    level_t               last_level;
    level_t               click_dir;
    logic [TIME_W-1:0]    click_time;
    logic                 sticky_flag;
    logic [COUNT_W-1:0]   pulse_count;
  } entry_t;

  typedef struct packed {
    logic                 double_click;
    logic                 click_negative;
    logic [COUNT_W-1:0]   taken_count;
    logic                 taken_flag;
  } result_t;

endpackage

// File: hw/rtl/idcd_if.sv
// ----------------------------------------------------------------------------
// idcd_if
// Request and result channels of the impulse double-click detector.
// ----------------------------------------------------------------------------
interface idcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  player;
  logic [5:0]  control_index;
  logic signed [15:0] position;
  logic [31:0] time_ms;

  modport source (output valid, req_type, player, control_index, position, time_ms,
                  input ready);
  modport sink   (input valid, req_type, player, control_index, position, time_ms,
                  output ready);
endinterface

interface idcd_out_if;
  logic        valid;
  logic        ready;
  logic        double_click;
  logic        click_negative;
  logic [14:0] taken_count;
  logic        taken_flag;

  modport source (output valid, double_click, click_negative, taken_count, taken_flag,
                  input ready);
  modport sink   (input valid, double_click, click_negative, taken_count, taken_flag,
                  output ready);
endinterface

// File: hw/rtl/idcd_entry_logic.sv
// ----------------------------------------------------------------------------
// idcd_entry_logic
// Computes the new table entry and the result for one request.
// ----------------------------------------------------------------------------
module idcd_entry_logic
  import idcd_pkg::*;
(
  input  req_t                      req,
  input  logic signed [POS_W-1:0]   position,
  input  logic [TIME_W-1:0]         time_ms,
  input  logic [THRESH_W-1:0]       threshold,
  input  entry_t                    cur,
  output entry_t                    nxt,
  output result_t                   res
);

  level_t            cls;
  level_t            act;
  logic [TIME_W-1:0] dt;
  logic              in_window;

  always_comb begin
    if (position > POS_HALF) begin
      cls = LVL_POS;
    end else if (position < NEG_HALF) begin
      cls = LVL_NEG;
    end else begin
      cls = LVL_RELEASED;
    end
  end

  assign act       = (req == REQ_PULSE) ? LVL_POS : cls;
  assign dt        = time_ms - cur.click_time;
  assign in_window = dt < {{(TIME_W-THRESH_W){1'b0}}, threshold};

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (req)
      REQ_SAMPLE, REQ_PULSE: begin
        if ((req == REQ_PULSE) && (cur.pulse_count != COUNT_MAX)) begin
          nxt.pulse_count = cur.pulse_count + 1'b1;
        end
        if (threshold == '0) begin
          nxt.sticky_flag = 1'b0;
          nxt.click_time  = '0;
          nxt.click_dir   = LVL_RELEASED;
        end else begin
          if ((act != LVL_RELEASED) && (act != cur.last_level)) begin
            if ((act == cur.click_dir) && in_window) begin
              nxt.sticky_flag    = 1'b1;
              res.double_click   = 1'b1;
              res.click_negative = (act == LVL_NEG);
            end
            nxt.click_time = time_ms;
            nxt.click_dir  = act;
            nxt.last_level = act;
          end
          // A pulse ends with its release half.
          if ((act == LVL_RELEASED) || (req == REQ_PULSE)) begin
            nxt.last_level = LVL_RELEASED;
          end
        end
      end
      REQ_TAKE_COUNT: begin
        res.taken_count = cur.pulse_count;
        nxt.pulse_count = '0;
      end
      REQ_TAKE_FLAG: begin
        res.taken_flag  = cur.sticky_flag;
        nxt.sticky_flag = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/impulse_double_click_detector.sv
// ----------------------------------------------------------------------------
// impulse_double_click_detector
// Per player and control click table with double-click detection,
// pulse counting and read-and-clear requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    req_type, player, control_index, position, time_ms
// out_ch    out        valid/ready    double_click, click_negative, taken_count, taken_flag
// cfg       in         cfg_we         cfg_wdata = threshold_ms
//
// One request is accepted per cycle unless the output stalls; it waits in the s1 stage
// registers and its result is then registered. The table memory is read when a request
// is accepted and written when it leaves the s1 stage, with the last write forwarded
// to a request for the same entry. After reset a clearing pass writes zero to each of
// the NUM_PLAYERS * NUM_CONTROLS entries in turn, during which no request is accepted.
// A stalled result register holds the stage before it, which then holds the input.
// ----------------------------------------------------------------------------
module impulse_double_click_detector
  import idcd_pkg::*;
#(
  parameter int NUM_PLAYERS  = NUM_PLAYERS_DEF,
  parameter int NUM_CONTROLS = NUM_CONTROLS_DEF
)
(
  input  logic                clk,
  input  logic                rst_n,
  idcd_in_if.sink             in_ch,
  idcd_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata
);

  localparam int ENTRIES = NUM_PLAYERS * NUM_CONTROLS;
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  entry_t                    mem [ENTRIES];

  logic [THRESH_W-1:0]       thresh_r;
  logic                      clr_active_r;
  logic [ENTRY_W-1:0]        clr_addr_r;

  logic                      s1_valid_r;
  req_t                      s1_req_r;
  logic signed [POS_W-1:0]   s1_pos_r;
  logic [TIME_W-1:0]         s1_time_r;
  logic [ENTRY_W-1:0]        s1_addr_r;
  logic                      s1_inrange_r;
  entry_t                    rd_r;

  logic                      byp_valid_r;
  logic [ENTRY_W-1:0]        byp_addr_r;
  entry_t                    byp_data_r;

  logic                      out_valid_r;
  result_t                   out_res_r;

  logic                      in_accept;
  logic                      s1_fire;
  logic                      in_inrange;
  logic [ENTRY_W-1:0]        in_addr;
  entry_t                    cur_entry;
  entry_t                    nxt_entry;
  result_t                   res;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr_active_r && (!s1_valid_r || s1_fire);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_inrange  = (32'(in_ch.player) < 32'(NUM_PLAYERS)) &&
                       (32'(in_ch.control_index) < 32'(NUM_CONTROLS));
  assign in_addr     = ENTRY_W'(32'(in_ch.player) * 32'(NUM_CONTROLS) +
                                32'(in_ch.control_index));
  assign cur_entry   = (byp_valid_r && (byp_addr_r == s1_addr_r)) ? byp_data_r : rd_r;

  idcd_entry_logic u_entry_logic (
    .req       (s1_req_r),
    .position  (s1_pos_r),
    .time_ms   (s1_time_r),
    .threshold (thresh_r),
    .cur       (cur_entry),
    .nxt       (nxt_entry),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (s1_fire && s1_inrange_r) begin
      mem[s1_addr_r] <= nxt_entry;
    end
    if (in_accept) begin
      rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RESET;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      byp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ENTRY_W'(ENTRIES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire && s1_inrange_r) begin
        byp_valid_r <= 1'b1;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r     <= req_t'(in_ch.req_type);
      s1_pos_r     <= in_ch.position;
      s1_time_r    <= in_ch.time_ms;
      s1_addr_r    <= in_addr;
      s1_inrange_r <= in_inrange;
    end
    if (s1_fire && s1_inrange_r) begin
      byp_addr_r <= s1_addr_r;
      byp_data_r <= nxt_entry;
    end
    if (s1_fire) begin
      out_res_r <= s1_inrange_r ? res : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.double_click   = out_res_r.double_click;
  assign out_ch.click_negative = out_res_r.click_negative;
  assign out_ch.taken_count    = out_res_r.taken_count;
  assign out_ch.taken_flag     = out_res_r.taken_flag;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ch.ready)
    else $error("request accepted during the clearing pass");

  a_no_bypass_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !byp_valid_r)
    else $error("forwarding register valid during the clearing pass");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_event_excludes_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.double_click) |->
      (out_res_r.taken_count == '0) && !out_res_r.taken_flag)
    else $error("double-click event on a read-and-clear result");
`endif

endmodule
